@@ src/lift_mode_sequencer_p_control_defines.svh @@
// Assertion macros for the lift mode sequencer.
// No dependencies; included by the RTL file that asserts.
`ifndef LIFT_MODE_SEQUENCER_P_CONTROL_DEFINES_SVH
`define LIFT_MODE_SEQUENCER_P_CONTROL_DEFINES_SVH
`ifndef SYNTHESIS
`define LMS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("lms");
`define LMS_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) else $error("lms");
`else
`define LMS_ASSERT(label, clk, rstn, prop)
`define LMS_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ src/lms_pkg.sv @@
// Package for the lift mode sequencer: mode codes, sequencer states, constants.
// No dependencies.
package lms_pkg;
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_READY   = 3'd1,
        MODE_HOLD    = 3'd2,
        MODE_DROP    = 3'd3,
        MODE_ABORTED = 3'd4
    } lift_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIFT_MUL,
        ST_LIFT_DIV,
        ST_REL_MUL,
        ST_REL_DIV,
        ST_OUT
    } seq_state_t;

    localparam int unsigned DIVISOR   = 127 * 1024;
    localparam int unsigned VOLT_MAX  = 12000;
    localparam int unsigned QUO_BITS  = 32;

    localparam logic [2:0] OPT_NONE   = 3'd0;
    localparam logic [2:0] OPT_RIGHT  = 3'd1;
    localparam logic [2:0] OPT_LEFT   = 3'd2;
    localparam logic [2:0] OPT_FORCE  = 3'd3;
    localparam logic [2:0] OPT_YELLOW = 3'd4;
    localparam logic [2:0] OPT_STICK  = 3'd5;
    localparam logic [2:0] OPT_BACK   = 3'd6;

    localparam logic signed [14:0] ROT_P127 = 15'sd12000;
    localparam logic signed [14:0] ROT_N127 = -15'sd12000;
    localparam logic signed [14:0] ROT_P100 = 15'sd9448;
    localparam logic signed [14:0] ROT_N90  = -15'sd8503;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

@@ src/lms_divider.sv @@
// Divide by 127*1024: shift right by 10, then multiply by ceil(2^28/127) and keep
// the bits above 2^28 (exact for shifted values below 2^21). Depends on lms_pkg.
module lms_divider
    import lms_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [QUO_BITS-1:0] dividend,
    output div_ctl_t            ctl,
    output logic [QUO_BITS-1:0] quotient
);
    localparam int unsigned XB     = 21;      // dividend >> 10 stays below 2^21
    localparam int unsigned PW     = 43;      // 21 x 22 bit product
    localparam int unsigned LO_SH  = 10;      // divide by 1024
    localparam int unsigned RC_SH  = 28;
    localparam logic [21:0] RECIP  = 22'd2113666;   // ceil(2^28 / 127)

    logic [XB-1:0] x_reg, x_next;
    logic [PW-1:0] p_reg, p_next;
    logic          busy_reg, busy_next, done_reg, done_next;

    always_comb begin
        x_next = x_reg; p_next = p_reg;
        busy_next = 1'b0; done_next = 1'b0;
        if (start) begin
            x_next = XB'(dividend >> LO_SH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            p_next = PW'(x_reg) * PW'(RECIP);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next; p_reg <= p_next;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    assign quotient  = QUO_BITS'(p_reg[PW-1:RC_SH]);
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule

@@ src/lift_mode_sequencer_p_control.sv @@
// Lift mode sequencer: one tick per input word, one result word per tick.
// From accept to m_tvalid: per loop three steps on the shared
// multiplier and two on the shared reciprocal divider, then the output state.
// One word at a time: s_tready is low while a tick is in work or a result word waits.
// Reset (aresetn, synchronous, active low): mode idle, goals zero and active, regs zero.
// Depends on lms_pkg, lms_divider and lift_mode_sequencer_p_control_defines.svh.
`include "lift_mode_sequencer_p_control_defines.svh"
module lift_mode_sequencer_p_control
    import lms_pkg::*;
#(
    parameter int SPIN_OFFSET   = 200,
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // lift_position[15:0] release_position[31:16] optical_mode[34:32] sees_black[35]
    // button_spin_back[36] button_spin_fwd[37] button_advance[38] button_abort[39]
    // time_phase[48:40], zero fill to 56
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // lift_drive[14:0] release_drive[29:15] rotate_drive[44:30] clear_optical[45]
    // mode_now[48:46], zero fill to 56
    output logic [55:0] m_tdata
);
    localparam int PB = POSITION_BITS;
    localparam int EB = ((PB > 16) ? PB : 16) + 2;   // goal - position width
    localparam logic signed [PB-1:0] PMAX = {1'b0, {(PB-1){1'b1}}};
    localparam logic signed [PB-1:0] PMIN = {1'b1, {(PB-1){1'b0}}};

    logic [15:0] regs_reg [8];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) regs_reg[i] <= '0;
        end else if (cfg_we) begin
            regs_reg[cfg_index] <= cfg_wdata;
        end
    end

    function automatic logic signed [PB-1:0] sat_pos(input logic signed [31:0] x);
        if (x > 32'(signed'(PMAX))) return PMAX;
        if (x < 32'(signed'(PMIN))) return PMIN;
        return PB'(x);
    endfunction

    // input fields
    logic signed [15:0] lpos, rpos;
    logic [2:0] opt;
    logic black, btn_a, btn_y, adv, abrt;
    logic [8:0] phase;
    assign lpos = s_tdata[15:0];  assign rpos = s_tdata[31:16];
    assign opt = s_tdata[34:32];  assign black = s_tdata[35];
    assign btn_a = s_tdata[36];   assign btn_y = s_tdata[37];
    assign adv = s_tdata[38];     assign abrt = s_tdata[39];
    assign phase = s_tdata[48:40];

    lift_mode_t          mode_reg, mode_next;
    logic                adv_prev_reg;
    logic signed [PB-1:0] lgoal_reg, lgoal_next, rgoal_reg, rgoal_next;
    logic                loff_reg, loff_next, roff_reg, roff_next;
    logic signed [14:0]  rot_next, rot_reg;
    logic                clr_next, clr_reg, abort_reg;
    logic signed [EB-1:0] lerr_reg, rerr_reg;
    logic                offset, edge_det;
    lift_mode_t          m0;

    // tick decode, done at acceptance
    always_comb begin
        rot_next = '0; offset = 1'b0; clr_next = 1'b0;
        case (opt)
            OPT_RIGHT, OPT_FORCE:   rot_next = ROT_P127;
            OPT_LEFT:               rot_next = ROT_N127;
            OPT_YELLOW, OPT_STICK:  rot_next = black ? ROT_P100 : ROT_P127;
            OPT_BACK:               rot_next = ROT_N90;
            default:                rot_next = '0;
        endcase
        if (opt != OPT_NONE && opt != 3'd7) offset = 1'b1;
        m0 = mode_reg;
        if (btn_a) begin clr_next = 1'b1; m0 = MODE_HOLD; offset = 1'b1; rot_next = ROT_N127; end
        if (btn_y) begin clr_next = 1'b1; m0 = MODE_HOLD; offset = 1'b1; rot_next = ROT_P127; end
        edge_det = adv && !adv_prev_reg;
        mode_next = m0; lgoal_next = lgoal_reg; rgoal_next = rgoal_reg;
        loff_next = loff_reg; roff_next = roff_reg;
        unique case (m0)
            MODE_IDLE: if (edge_det) mode_next = MODE_READY;
            MODE_READY: begin
                lgoal_next = sat_pos(32'(signed'(regs_reg[0])));
                rgoal_next = sat_pos(32'(signed'(regs_reg[3])));
                loff_next = 1'b0; roff_next = 1'b0;
                if (edge_det) mode_next = MODE_HOLD;
            end
            MODE_HOLD: begin
                lgoal_next = sat_pos(32'(signed'(regs_reg[1]))
                                     - (offset ? 32'(SPIN_OFFSET) : 32'sd0));
                rgoal_next = sat_pos(32'(signed'(regs_reg[4])));
                loff_next = 1'b0; roff_next = 1'b0;
                if (edge_det) mode_next = MODE_DROP;
            end
            MODE_DROP: begin
                lgoal_next = sat_pos(32'(signed'(regs_reg[2])));
                rgoal_next = sat_pos(32'(signed'(regs_reg[5])));
                loff_next = 1'b0; roff_next = 1'b0;
                rot_next = (phase > 9'd250) ? ROT_P127 : ROT_N127;
                if (edge_det) mode_next = MODE_READY;
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    // shared multiplier + divider sequencer
    seq_state_t st_reg, st_next;
    logic [EB-2:0]  mag_reg;       // |err|
    logic           neg_reg;
    logic [63:0]    prod_reg;      // |err| * gain (fits)
    logic [15:0]    gain_sel;
    logic           div_start;
    div_ctl_t       dctl;
    logic [QUO_BITS-1:0] quo;
    logic signed [14:0] ld_reg, rd_reg;
    logic           step_mul;
    logic [1:0]     mphase_reg;
    logic signed [EB-1:0] err_sel;
    logic accept;
    logic mul_off_l, mul_off_r;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (st_reg == ST_IDLE) && !m_tvalid;

    function automatic logic signed [14:0] sat_drive(input logic [QUO_BITS-1:0] q,
                                                     input logic n);
        logic signed [14:0] v;
        v = (q > QUO_BITS'(VOLT_MAX)) ? 15'sd12000 : 15'(q);
        return n ? -v : v;
    endfunction

    assign err_sel = (st_reg == ST_LIFT_MUL) ? lerr_reg : rerr_reg;
    assign gain_sel = (st_reg == ST_LIFT_MUL) ? regs_reg[6] : regs_reg[7];
    assign div_start = (st_reg == ST_LIFT_MUL || st_reg == ST_REL_MUL) && mphase_reg == 2'd2;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:     if (accept) st_next = ST_LIFT_MUL;
            ST_LIFT_MUL: if (mphase_reg == 2'd2) st_next = ST_LIFT_DIV;
            ST_LIFT_DIV: if (dctl.done) st_next = ST_REL_MUL;
            ST_REL_MUL:  if (mphase_reg == 2'd2) st_next = ST_REL_DIV;
            ST_REL_DIV:  if (dctl.done) st_next = ST_OUT;
            ST_OUT:      st_next = ST_IDLE;
            default:     st_next = ST_IDLE;
        endcase
    end
    assign step_mul = (st_reg == ST_LIFT_MUL || st_reg == ST_REL_MUL);

    always_ff @(posedge aclk) begin
        if (accept) begin
            rot_reg <= rot_next; clr_reg <= clr_next || abrt; abort_reg <= abrt;
            lerr_reg <= EB'(lgoal_next) - EB'(lpos);
            rerr_reg <= EB'(rgoal_next) - EB'(rpos);
        end
        // phase 0: magnitude, phase 1: *gain, phase 2: *12000 (combinational) starts the divider
        if (step_mul) begin
            if (mphase_reg == 2'd0) begin
                neg_reg <= err_sel[EB-1];
                mag_reg <= (EB-1)'(err_sel[EB-1] ? -err_sel : err_sel);
            end else if (mphase_reg == 2'd1) begin
                prod_reg <= 64'(mag_reg) * 64'(gain_sel);
            end
        end
        if (st_reg == ST_LIFT_DIV && dctl.done) ld_reg <= sat_drive(quo, neg_reg);
        if (st_reg == ST_REL_DIV && dctl.done) rd_reg <= sat_drive(quo, neg_reg);
        if (!aresetn) begin
            st_reg <= ST_IDLE; mphase_reg <= '0; m_tvalid <= 1'b0;
            mode_reg <= MODE_IDLE; adv_prev_reg <= 1'b0;
            lgoal_reg <= '0; rgoal_reg <= '0; loff_reg <= 1'b0; roff_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            mphase_reg <= step_mul && mphase_reg != 2'd2 ? mphase_reg + 2'd1 : 2'd0;
            if (accept) begin
                adv_prev_reg <= adv;
                mode_reg <= abrt ? MODE_ABORTED : mode_next;
                lgoal_reg <= lgoal_next; rgoal_reg <= rgoal_next;
                loff_reg <= abrt ? 1'b1 : loff_next;
                roff_reg <= abrt ? 1'b1 : roff_next;
                // goal-off flags before abort gate the loops
                mul_off_l <= loff_next; mul_off_r <= roff_next;
            end
            if (st_reg == ST_OUT) m_tvalid <= 1'b1;
            else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
        end
    end

    // product * 12000 fed to divider; |err|*gain < 2^34, *12000 < 2^48, but
    // saturation above 13000*127*1024 keeps the dividend in 32 bits
    logic [63:0] big;
    logic [QUO_BITS-1:0] dvd;
    assign big = prod_reg * 64'(VOLT_MAX);
    assign dvd = (big >= 64'(DIVISOR) * 64'(13000)) ? QUO_BITS'(DIVISOR * 13000)
                                                    : QUO_BITS'(big);

    lms_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(dvd), .ctl(dctl), .quotient(quo)
    );

    logic signed [14:0] ld_out, rd_out;
    assign ld_out = (mul_off_l || abort_reg) ? 15'sd0 : ld_reg;
    assign rd_out = mul_off_r ? 15'sd0 : rd_reg;
    assign m_tdata = {7'd0, 3'(mode_reg), clr_reg, rot_reg, rd_out, ld_out};

    `LMS_ASSERT(a_busy_no_ready, aclk, aresetn, (st_reg != ST_IDLE) |-> !s_tready)
    `LMS_ASSERT(a_accept_starts, aclk, aresetn, accept |=> (st_reg == ST_LIFT_MUL))
    `LMS_ASSERT(a_abort_mode, aclk, aresetn,
        (accept && abrt) |=> (mode_reg == MODE_ABORTED))
    `LMS_ASSERT(a_drive_range, aclk, aresetn,
        m_tvalid |-> (ld_out <= 15'sd12000 && ld_out >= -15'sd12000))
endmodule
